>>> src/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;
	localparam int NSEG = 256;
	localparam int IDX_W = 8;
	localparam int LNK_W = 9;
	localparam int ADDR_W = 32;
	localparam logic [LNK_W-1:0] NIL = LNK_W'(NSEG);

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE = 2'd2,
		OP_MERGE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [31:0] request_size;
		logic [4:0] align_log2;
		logic [31:0] release_address;
	} in_word_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [1:0] status;
	} out_word_t;
endpackage

>>> src/first_fit_range_allocator.sv
`timescale 1ns / 1ps
// Allocate walks the free list record by record; free scans up to 256 records for
// the released address, then walks the free list for its place; merge walks the
// free list once, joining each record to the next where they touch.
// One word at a time: in_ready is low while a word is in progress; a result waiting
// in the output register lets the next word run but holds it in S_DONE until taken.
// arst_n clears control state, lists and spare stack pointer; memories are not reset.
module first_fit_range_allocator (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input ffra_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output ffra_pkg::out_word_t out_data
);
	import ffra_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE = 15'd1,
		S_RD = 15'd2,
		S_WAIT = 15'd4,
		S_AEVAL = 15'd8,
		S_AW1 = 15'd16,
		S_AW2 = 15'd32,
		S_AW3 = 15'd64,
		S_FSCAN = 15'd128,
		S_FSEVAL = 15'd256,
		S_FWALK = 15'd512,
		S_FLINK = 15'd1024,
		S_MEVAL = 15'd2048,
		S_MNRD = 15'd4096,
		S_MNEVAL = 15'd8192,
		S_DONE = 15'd16384
	} state_t;

	state_t state_q;
	logic [31:0] total_q;
	in_word_t req_q;
	logic [LNK_W-1:0] head_q, cur_q, prev_q, nxt_q;
	logic [LNK_W-1:0] top_q;
	logic [NSEG-1:0] mark_q;
	logic [8:0] steps_q;
	logic [31:0] cbase_q, clen_q;
	logic [31:0] gap_q;
	logic [IDX_W-1:0] rec_q, drop_q;
	logic [1:0] stat_q;
	logic [31:0] grant_q;
	out_word_t out_q;
	logic done_go;

	// memory ports
	logic b_we, l_we, n_we, s_we;
	logic [IDX_W-1:0] b_wa, l_wa, n_wa, s_wa, b_ra, l_ra, n_ra, s_ra;
	logic [31:0] b_wd, l_wd, b_rd, l_rd;
	logic [LNK_W-1:0] n_wd, n_rd;
	logic [IDX_W-1:0] s_wd, s_rd;

	ffra_ram #(.WIDTH(32), .DEPTH(NSEG)) u_base (.clk, .we(b_we), .waddr(b_wa),
		.wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
	ffra_ram #(.WIDTH(32), .DEPTH(NSEG)) u_len (.clk, .we(l_we), .waddr(l_wa),
		.wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
	ffra_ram #(.WIDTH(LNK_W), .DEPTH(NSEG)) u_next (.clk, .we(n_we), .waddr(n_wa),
		.wdata(n_wd), .raddr(n_ra), .rdata(n_rd));
	// spare stack: an entry never written reads as its own index (init state)
	logic [NSEG-1:0] svld_q;
	logic [IDX_W-1:0] s_rd_eff, s_ra_q;
	ffra_ram #(.WIDTH(IDX_W), .DEPTH(NSEG)) u_spare (.clk, .we(s_we), .waddr(s_wa),
		.wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
	logic s_vld_q;
	assign s_rd_eff = s_vld_q ? s_rd : s_ra_q;

	// shared arithmetic
	logic [31:0] amask, gap_c, avail;
	logic [32:0] fit_sum;
	logic fits;
	assign amask = (32'd1 << req_q.align_log2) - 32'd1;
	assign gap_c = (32'd0 - b_rd) & amask;
	assign avail = l_rd - gap_c;
	assign fit_sum = {1'b0, gap_c} + {1'b0, req_q.request_size};
	assign fits = fit_sum <= {1'b0, l_rd};
	logic [31:0] mdiff;
	assign mdiff = b_rd - cbase_q;

	// the output register frees the engine; a finished word waits in S_DONE
	assign in_ready = state_q[0];
	assign out_data = out_q;
	assign done_go = (state_q == S_DONE) && (!out_valid || out_ready);

	logic [LNK_W-1:0] top_m1, top_m2;
	assign top_m1 = top_q - LNK_W'(1);
	assign top_m2 = top_q - LNK_W'(2);

	always_comb begin
		b_we = 1'b0; l_we = 1'b0; n_we = 1'b0; s_we = 1'b0;
		b_wa = cur_q[IDX_W-1:0]; l_wa = cur_q[IDX_W-1:0]; n_wa = cur_q[IDX_W-1:0];
		s_wa = top_q[IDX_W-1:0];
		b_wd = '0; l_wd = '0; n_wd = NIL; s_wd = cur_q[IDX_W-1:0];
		b_ra = cur_q[IDX_W-1:0]; l_ra = cur_q[IDX_W-1:0]; n_ra = cur_q[IDX_W-1:0];
		s_ra = top_m1[IDX_W-1:0];
		unique case (state_q)
			S_AEVAL: s_ra = top_m1[IDX_W-1:0];
			S_AW1: begin
				s_ra = top_m2[IDX_W-1:0];
				b_we = 1'b1; l_we = 1'b1; n_we = 1'b1;
				b_wa = s_rd_eff; l_wa = s_rd_eff; n_wa = s_rd_eff;
				b_wd = cbase_q + gap_q; l_wd = req_q.request_size; n_wd = NIL;
			end
			S_AW2: begin
				b_we = 1'b1; l_we = 1'b1; n_we = 1'b1;
				b_wa = s_rd_eff; l_wa = s_rd_eff; n_wa = s_rd_eff;
				b_wd = cbase_q; l_wd = gap_q; n_wd = cur_q;
			end
			S_AW3: begin
				b_we = 1'b1; l_we = 1'b1;
				b_wd = cbase_q + gap_q + req_q.request_size;
				l_wd = clen_q - gap_q - req_q.request_size;
				n_we = (gap_q != '0) && prev_q != NIL;
				n_wa = prev_q[IDX_W-1:0]; n_wd = {1'b0, drop_q};
			end
			S_FSCAN: b_ra = steps_q[IDX_W-1:0];
			S_FLINK: begin
				n_we = 1'b1; n_wa = rec_q; n_wd = cur_q;
			end
			S_MNRD: begin
				b_ra = nxt_q[IDX_W-1:0]; l_ra = nxt_q[IDX_W-1:0];
			end
			S_MNEVAL: begin
				if (b_rd >= cbase_q && mdiff == clen_q) begin
					b_we = 1'b1; l_we = 1'b1;
					b_wa = nxt_q[IDX_W-1:0]; l_wa = nxt_q[IDX_W-1:0];
					b_wd = cbase_q; l_wd = l_rd + clen_q;
					n_we = prev_q != NIL; n_wa = prev_q[IDX_W-1:0]; n_wd = nxt_q;
					s_we = top_q != NIL;
				end
				b_ra = nxt_q[IDX_W-1:0]; l_ra = nxt_q[IDX_W-1:0];
				n_ra = nxt_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && req_q.opcode == OP_FREE && stat_q == ST_OK) begin
			// free: link previous to the released record
			n_we = 1'b1; n_wa = prev_q[IDX_W-1:0]; n_wd = {1'b0, rec_q};
			if (prev_q == NIL) n_we = 1'b0;
		end
		if (state_q == S_DONE && req_q.opcode == OP_INIT) begin
			b_we = 1'b1; l_we = 1'b1; n_we = 1'b1;
			b_wa = IDX_W'(NSEG - 1); l_wa = IDX_W'(NSEG - 1); n_wa = IDX_W'(NSEG - 1);
			b_wd = '0; l_wd = total_q; n_wd = NIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; total_q <= '0; head_q <= NIL; top_q <= LNK_W'(NSEG);
			mark_q <= '0; svld_q <= '0; out_valid <= 1'b0; s_vld_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) total_q <= cfg_wdata;
			s_ra_q <= s_ra; s_vld_q <= svld_q[s_ra];
			if (s_we) svld_q[s_wa] <= 1'b1;
			if (done_go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					req_q <= in_data; stat_q <= ST_OK; grant_q <= '0;
					cur_q <= head_q; prev_q <= NIL; steps_q <= '0;
					unique case (op_t'(in_data.opcode))
						OP_INIT: state_q <= S_DONE;
						OP_FREE: state_q <= S_FSCAN;
						default: state_q <= S_RD;
					endcase
				end
				S_RD: begin
					if (cur_q == NIL || steps_q == 9'(NSEG)) begin
						stat_q <= (req_q.opcode == OP_ALLOC) ? ST_NOFIT : ST_OK;
						state_q <= S_DONE;
					end else state_q <= S_WAIT;
				end
				S_WAIT: state_q <= (req_q.opcode == OP_ALLOC) ? S_AEVAL : S_MEVAL;
				S_AEVAL: begin
					cbase_q <= b_rd; clen_q <= l_rd; gap_q <= gap_c;
					if (gap_c <= l_rd && fits && avail >= req_q.request_size) begin
						if (top_q < ((gap_c != '0) ? LNK_W'(2) : LNK_W'(1))) begin
							stat_q <= ST_EMPTY; state_q <= S_DONE;
						end else state_q <= S_AW1;
					end else begin
						prev_q <= cur_q; cur_q <= n_rd; steps_q <= steps_q + 9'd1;
						state_q <= S_RD;
					end
				end
				S_AW1: begin
					mark_q[s_rd_eff] <= 1'b1; grant_q <= cbase_q + gap_q;
					top_q <= top_m1;
					state_q <= (gap_q != '0) ? S_AW2 : S_AW3;
				end
				S_AW2: begin
					drop_q <= s_rd_eff; top_q <= top_m1;
					if (prev_q == NIL) head_q <= {1'b0, s_rd_eff};
					state_q <= S_AW3;
				end
				S_AW3: state_q <= S_DONE;
				S_FSCAN: state_q <= S_FSEVAL;
				S_FSEVAL: begin
					if (mark_q[steps_q[IDX_W-1:0]] &&
						b_rd == req_q.release_address) begin
						rec_q <= steps_q[IDX_W-1:0];
						mark_q[steps_q[IDX_W-1:0]] <= 1'b0;
						steps_q <= '0; state_q <= S_FWALK;
					end else if (steps_q == 9'(NSEG - 1)) begin
						stat_q <= ST_NOTFOUND; state_q <= S_DONE;
					end else begin
						steps_q <= steps_q + 9'd1; state_q <= S_FSCAN;
					end
				end
				S_FWALK: begin
					if (cur_q == NIL || steps_q == 9'(NSEG)) begin
						state_q <= S_FLINK;
					end else begin
						state_q <= S_MEVAL;
					end
				end
				S_FLINK: begin
					if (prev_q == NIL) head_q <= {1'b0, rec_q};
					state_q <= S_DONE;
				end
				S_MEVAL: begin
					if (req_q.opcode == OP_FREE) begin
						// cur data comes through the registered RAM read; reuse the merge states as the wait
						state_q <= S_MNRD;
					end else begin
						cbase_q <= b_rd; clen_q <= l_rd; nxt_q <= n_rd;
						if (n_rd == NIL) begin
							prev_q <= cur_q; cur_q <= n_rd; steps_q <= steps_q + 9'd1;
							state_q <= S_RD;
						end else state_q <= S_MNRD;
					end
				end
				S_MNRD: begin
					if (req_q.opcode == OP_FREE) begin
						if (req_q.release_address < b_rd) state_q <= S_FLINK;
						else begin
							prev_q <= cur_q; cur_q <= n_rd; steps_q <= steps_q + 9'd1;
							state_q <= S_FWALK;
						end
					end else state_q <= S_MNEVAL;
				end
				S_MNEVAL: begin
					if (b_rd >= cbase_q && mdiff == clen_q) begin
						if (prev_q == NIL) head_q <= nxt_q;
						if (top_q != NIL) top_q <= top_q + LNK_W'(1);
					end else prev_q <= cur_q;
					cur_q <= nxt_q; steps_q <= steps_q + 9'd1;
					state_q <= S_RD;
				end
				S_DONE: if (done_go) begin
					if (req_q.opcode == OP_INIT) begin
						head_q <= LNK_W'(NSEG - 1); top_q <= LNK_W'(NSEG - 1);
						mark_q <= '0; svld_q <= '0;
					end
					out_q.granted_address <= grant_q; out_q.status <= stat_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> src/ffra_ram.sv
`timescale 1ns / 1ps
module ffra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/ffra_checker.sv
`timescale 1ns / 1ps
module ffra_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input ffra_pkg::out_word_t out_data
);
	import ffra_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.granted_address == '0)
		else $error("nonzero grant on failure");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted back to back");
endmodule

bind first_fit_range_allocator ffra_checker u_chk (.clk, .arst_n, .in_valid, .in_ready,
	.out_valid, .out_ready, .out_data);

>>> sim/first_fit_range_allocator_test.sv
`timescale 1ns / 1ps
module first_fit_range_allocator_test;
	import ffra_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int ITEM_GOAL = 1550;

	class alloc_scoreboard;
		logic [31:0] seg_base[NSEG];
		logic [31:0] seg_len[NSEG];
		logic [LNK_W-1:0] link[NSEG];
		bit used[NSEG];
		logic [LNK_W-1:0] head;
		logic [IDX_W-1:0] spare[NSEG];
		int top;
		logic [31:0] range_size;
		out_word_t want[$];
		int errors;

		function new();
			range_size = 0;
			errors = 0;
			refill();
		endfunction

		function void refill();
			for (int i = 0; i < NSEG; i++) begin
				spare[i] = IDX_W'(i);
				used[i] = 0;
			end
			top = NSEG;
			head = NIL;
		endfunction

		function int pop_rec();
			top--;
			return int'(spare[top]);
		endfunction

		function void push_rec(int r);
			if (top < NSEG) begin
				spare[top] = IDX_W'(r);
				top++;
			end
		endfunction

		function void splice(logic [LNK_W-1:0] prev, int r, logic [LNK_W-1:0] nxt);
			link[r] = nxt;
			if (prev < NSEG)
				link[prev] = LNK_W'(r);
			else
				head = LNK_W'(r);
		endfunction

		// first-fit with alignment; the gap before the aligned start becomes its own segment
		function status_t grab(logic [31:0] req, logic [4:0] lg, output logic [31:0] addr);
			logic [31:0] amask, b, l, gap, aligned;
			logic [LNK_W-1:0] prev, cur;
			int rec, drop;
			amask = (32'd1 << lg) - 32'd1;
			prev = NIL;
			cur = head;
			addr = 0;
			for (int s = 0; s < NSEG && cur < NSEG; s++) begin
				b = seg_base[cur];
				l = seg_len[cur];
				gap = (32'd0 - b) & amask;
				if (gap <= l && req <= l - gap) begin
					aligned = b + gap;
					if (top < ((gap != 0) ? 2 : 1))
						return ST_EMPTY;
					rec = pop_rec();
					seg_base[rec] = aligned;
					seg_len[rec] = req;
					used[rec] = 1;
					link[rec] = NIL;
					if (gap != 0) begin
						drop = pop_rec();
						seg_base[drop] = b;
						seg_len[drop] = gap;
						splice(prev, drop, cur);
					end
					seg_len[cur] = l - gap - req;
					seg_base[cur] = aligned + req;
					addr = aligned;
					return ST_OK;
				end
				prev = cur;
				cur = link[cur];
			end
			return ST_NOFIT;
		endfunction

		function status_t release_rec(logic [31:0] addr);
			int rec;
			logic [LNK_W-1:0] prev, cur;
			rec = -1;
			for (int i = 0; i < NSEG; i++)
				if (rec < 0 && used[i] && seg_base[i] == addr)
					rec = i;
			if (rec < 0)
				return ST_NOTFOUND;
			used[rec] = 0;
			prev = NIL;
			cur = head;
			for (int s = 0; s < NSEG && cur < NSEG; s++) begin
				if (addr < seg_base[cur])
					break;
				prev = cur;
				cur = link[cur];
			end
			if (cur >= NSEG)
				cur = NIL;
			splice(prev, rec, cur);
			return ST_OK;
		endfunction

		function void coalesce();
			logic [LNK_W-1:0] prev, cur, nxt;
			prev = NIL;
			cur = head;
			for (int s = 0; s < NSEG && cur < NSEG; s++) begin
				nxt = link[cur];
				if (nxt < NSEG && seg_base[nxt] >= seg_base[cur] &&
				    seg_base[nxt] - seg_base[cur] == seg_len[cur]) begin
					seg_base[nxt] = seg_base[cur];
					seg_len[nxt] = seg_len[nxt] + seg_len[cur];
					if (prev < NSEG)
						link[prev] = nxt;
					else
						head = nxt;
					push_rec(int'(cur));
				end else begin
					prev = cur;
				end
				cur = nxt;
			end
		endfunction

		function void note_input(in_word_t w);
			out_word_t res;
			logic [31:0] addr;
			int r;
			res = '0;
			case (op_t'(w.opcode))
				OP_INIT: begin
					refill();
					r = pop_rec();
					seg_base[r] = 0;
					seg_len[r] = range_size;
					link[r] = NIL;
					head = LNK_W'(r);
				end
				OP_ALLOC: begin
					res.status = grab(w.request_size, w.align_log2, addr);
					if (res.status == ST_OK)
						res.granted_address = addr;
				end
				OP_FREE: res.status = release_rec(w.release_address);
				default: coalesce();
			endcase
			want.push_back(res);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp_w;
			if (want.size() == 0) begin
				$display("%0t: unexpected word %h", $realtime, got);
				errors++;
				return;
			end
			exp_w = want.pop_front();
			if (got.granted_address !== exp_w.granted_address) begin
				$display("%0t: granted_address expected %h actual %h", $realtime,
					exp_w.granted_address, got.granted_address);
				errors++;
			end
			if (got.status !== exp_w.status) begin
				$display("%0t: status expected %0d actual %0d", $realtime,
					exp_w.status, got.status);
				errors++;
			end
		endfunction

		// base of a random live allocation, for well-formed frees
		function logic [31:0] live_address();
			int picks[$];
			for (int i = 0; i < NSEG; i++)
				if (used[i])
					picks.push_back(i);
			if (picks.size() == 0)
				return $urandom;
			return seg_base[picks[$urandom_range(0, picks.size() - 1)]];
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_data;

	alloc_scoreboard sb = new();
	bit hold_req = 0;
	int quiet = 0;
	int sent = 0;

	first_fit_range_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #1 clk = ~clk;

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end else begin
				g = pick_gap();
				if (g > 0) begin
					out_ready <= 0;
					repeat (g) @(posedge clk);
				end
				out_ready <= 1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	task automatic send_word(in_word_t w);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= w;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(w);
		sent++;
	endtask

	task automatic send_op(op_t op, logic [31:0] req = 0, logic [4:0] lg = 0,
			logic [31:0] addr = 0);
		in_word_t w;
		w.opcode = op;
		w.request_size = req;
		w.align_log2 = lg;
		w.release_address = addr;
		send_word(w);
	endtask

	// drop valid, let every result come back, then write the range size
	task automatic set_range(logic [31:0] v);
		in_valid <= 0;
		@(posedge clk);
		while (sb.want.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		sb.range_size = v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_op(logic [31:0] maxr, bit fill);
		int r;
		logic [31:0] req;
		logic [4:0] lg;
		logic [95:0] raw;
		r = $urandom_range(0, 99);
		req = (maxr == 0) ? $urandom_range(0, 3) : $urandom_range(0, maxr);
		lg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 6));
		if ($urandom_range(0, 19) == 0)
			req = $urandom;
		if (fill) begin
			if (r < 90)
				send_op(OP_ALLOC, req, (r < 70) ? 5'd0 : lg);
			else if (r < 96)
				send_op(OP_FREE, 0, 0, sb.live_address());
			else
				send_op(OP_MERGE);
		end else if (r < 45)
			send_op(OP_ALLOC, req, lg);
		else if (r < 75)
			send_op(OP_FREE, 0, 0, sb.live_address());
		else if (r < 80)
			send_op(OP_FREE, 0, 0, $urandom);
		else if (r < 92)
			send_op(OP_MERGE);
		else if (r < 95)
			send_op(OP_INIT);
		else begin
			raw = {$urandom, $urandom, $urandom};
			send_word(in_word_t'(raw[$bits(in_word_t)-1:0]));
		end
	endtask

	initial begin
		logic [31:0] range_v, maxr;
		int plen;
		bit fill;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// before any init
		send_op(OP_ALLOC, 4, 0);
		send_op(OP_FREE, 0, 0, 0);
		send_op(OP_MERGE);
		set_range(0);
		send_op(OP_INIT);
		send_op(OP_ALLOC, 0, 0);
		send_op(OP_ALLOC, 1, 0);
		set_range(32'hFFFF_FFFF);
		send_op(OP_INIT);
		send_op(OP_ALLOC, 32'hFFFF_FFFF, 0);
		send_op(OP_ALLOC, 0, 31);
		send_op(OP_FREE, 0, 0, 0);
		send_op(OP_FREE, 0, 0, 0);
		send_op(OP_MERGE);
		send_op(OP_INIT);
		send_op(OP_ALLOC, 5, 31);
		// big alignment gap split off in front
		send_op(OP_ALLOC, 3, 31);
		send_op(OP_FREE, 0, 0, 32'h8000_0000);
		send_op(OP_FREE, 0, 0, 0);
		send_op(OP_MERGE);
		send_op(OP_ALLOC, 16, 4);
		send_op(OP_FREE, 0, 0, 32'h1234_5678);
		send_op(OP_ALLOC, 32'hFFFF_FFFF, 0);

		// receiver holds off while words keep coming
		hold_req = 1;
		repeat (4) send_op(OP_ALLOC, $urandom_range(0, 100), 5'($urandom_range(0, 3)));

		while (sent < ITEM_GOAL) begin
			case ($urandom_range(0, 5))
				0: range_v = 32'hFFFF_FFFF;
				1: range_v = 32'd1 << $urandom_range(4, 16);
				2: range_v = $urandom_range(0, 3);
				default: range_v = $urandom;
			endcase
			set_range(range_v);
			maxr = range_v >> $urandom_range(3, 9);
			fill = ($urandom_range(0, 3) == 0);
			plen = fill ? $urandom_range(262, 300) : $urandom_range(60, 200);
			send_op(OP_INIT);
			for (int k = 0; k < plen && sent < ITEM_GOAL; k++)
				random_op(maxr, fill);
		end

		in_valid <= 0;
		@(posedge clk);
		while (sb.want.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.want.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
